// File: hdl/esd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	// Characters with a meaning to the decoder
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D7    = 8'h37;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// Control codes produced by the single-letter escapes
	localparam logic [7:0] CODE_BEL = 8'h07;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_HT  = 8'h09;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_VT  = 8'h0B;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_CR  = 8'h0D;

	// Result queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_end;
		logic       out_error;
	} out_word_t;

	// Up to two result words pushed per input word
	typedef struct packed {
		logic [1:0] cnt;
		out_word_t  w0;
		out_word_t  w1;
	} push_t;

endpackage

`default_nettype wire

// File: hdl/esd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_end;
	logic       out_error;

	modport source (output valid, output out_byte, output out_valid, output out_end,
		output out_error, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_end,
		input out_error, output ready);
endinterface

`default_nettype wire

// File: hdl/esd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_decode
	import esd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	esd_in_if.sink     rx,
	input  wire logic  room,
	output push_t      push
);

	typedef enum logic [2:0] {
		M_PLAIN = 3'd0,
		M_ESC   = 3'd1,
		M_XSTART = 3'd2,
		M_HEX   = 3'd3,
		M_OCT   = 3'd4
	} mode_t;

	// Hex digit value with a found flag in the top bit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			case (c) inside
				[CH_D0:CH_D9]: begin
					d = c - CH_D0;
					hex_val = {1'b1, d[3:0]};
				end
				[CH_LA:CH_LF]: begin
					d = c - CH_LA + 8'd10;
					hex_val = {1'b1, d[3:0]};
				end
				[CH_UA:CH_UF]: begin
					d = c - CH_UA + 8'd10;
					hex_val = {1'b1, d[3:0]};
				end
				default: hex_val = 5'd0;
			endcase
		end
	endfunction

	// Single-letter escape with a found flag in the top bit
	function automatic logic [8:0] letter_val(input logic [7:0] c);
		case (c)
			CH_LA:    letter_val = {1'b1, CODE_BEL};
			CH_LB:    letter_val = {1'b1, CODE_BS};
			CH_LF:    letter_val = {1'b1, CODE_FF};
			CH_LN:    letter_val = {1'b1, CODE_LF};
			CH_LR:    letter_val = {1'b1, CODE_CR};
			CH_LT:    letter_val = {1'b1, CODE_HT};
			CH_LV:    letter_val = {1'b1, CODE_VT};
			CH_BSL:   letter_val = {1'b1, CH_BSL};
			CH_QUOTE: letter_val = {1'b1, CH_QUOTE};
			CH_DQUOT: letter_val = {1'b1, CH_DQUOT};
			CH_QMARK: letter_val = {1'b1, CH_QMARK};
			default:  letter_val = 9'd0;
		endcase
	endfunction

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic       err_q, err_d;

	logic [7:0] em0, em1;
	logic [1:0] n;
	logic [4:0] hv;
	logic [8:0] lv;
	logic       oct;
	logic [7:0] odig;
	logic [1:0] cnt;
	out_word_t  w0, w1;

	assign advance  = valid_s1 && room;
	assign rx.ready = !valid_s1 || room;

	// Input register: hold a word until the queue has room for its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
			last_s1 <= rx.in_last;
		end
	end

	// Decode one character against the current mode
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		err_d  = err_q;
		em0    = 8'h00;
		em1    = 8'h00;
		n      = 2'd0;
		hv     = hex_val(byte_s1);
		lv     = letter_val(byte_s1);
		oct    = (byte_s1 >= CH_D0) && (byte_s1 <= CH_D7);
		odig   = byte_s1 - CH_D0;
		cnt    = 2'd0;
		w0     = '0;
		w1     = '0;

		if (!err_q) begin
			case (mode_q)
				M_ESC: begin
					if (lv[8]) begin
						em0    = lv[7:0];
						n      = 2'd1;
						mode_d = M_PLAIN;
					end else if (byte_s1 == CH_LX) begin
						mode_d = M_XSTART;
					end else if (oct) begin
						acc_d  = {5'd0, odig[2:0]};
						mode_d = M_OCT;
					end else begin
						err_d = 1'b1;
					end
				end
				M_XSTART: begin
					if (hv[4]) begin
						acc_d  = {4'd0, hv[3:0]};
						mode_d = M_HEX;
					end else begin
						err_d = 1'b1;
					end
				end
				M_HEX, M_OCT: begin
					if ((mode_q == M_HEX) ? hv[4] : oct) begin
						acc_d = (mode_q == M_HEX) ? {acc_q[3:0], hv[3:0]} :
							{acc_q[4:0], odig[2:0]};
					end else begin
						// Run ends: emit it, then treat the character as plain text
						em0   = acc_q;
						acc_d = 8'h00;
						if (byte_s1 == CH_BSL) begin
							mode_d = M_ESC;
							n      = 2'd1;
						end else begin
							mode_d = M_PLAIN;
							em1    = byte_s1;
							n      = 2'd2;
						end
					end
				end
				default: begin
					if (byte_s1 == CH_BSL) begin
						mode_d = M_ESC;
					end else begin
						mode_d = M_PLAIN;
						em0    = byte_s1;
						n      = 2'd1;
					end
				end
			endcase
		end

		// Close the string on its final character
		if (last_s1 && !err_d) begin
			if (mode_d == M_ESC || mode_d == M_XSTART) begin
				err_d = 1'b1;
			end else if (mode_d == M_HEX || mode_d == M_OCT) begin
				em0 = acc_d;
				n   = 2'd1;
			end
		end

		// Build the result words
		if (!last_s1) begin
			cnt = n;
			w0  = '{out_byte: em0, out_valid: 1'b1, out_end: 1'b0, out_error: 1'b0};
			w1  = '{out_byte: em1, out_valid: 1'b1, out_end: 1'b0, out_error: 1'b0};
		end else if (err_d) begin
			cnt = n + 2'd1;
			if (n == 2'd0) begin
				w0 = '{out_byte: 8'h00, out_valid: 1'b0, out_end: 1'b1, out_error: 1'b1};
			end else begin
				w0 = '{out_byte: em0, out_valid: 1'b1, out_end: 1'b0, out_error: 1'b0};
				w1 = '{out_byte: 8'h00, out_valid: 1'b0, out_end: 1'b1, out_error: 1'b1};
			end
		end else if (n == 2'd0) begin
			cnt = 2'd1;
			w0  = '{out_byte: 8'h00, out_valid: 1'b0, out_end: 1'b1, out_error: 1'b0};
		end else begin
			cnt = n;
			w0  = '{out_byte: em0, out_valid: 1'b1, out_end: (n == 2'd1), out_error: 1'b0};
			w1  = '{out_byte: em1, out_valid: 1'b1, out_end: 1'b1, out_error: 1'b0};
		end

		push.cnt = advance ? cnt : 2'd0;
		push.w0  = w0;
		push.w1  = w1;
	end

	// Advance decoder state; return to plain text after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PLAIN;
			acc_q  <= 8'h00;
			err_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				mode_q <= M_PLAIN;
				acc_q  <= 8'h00;
				err_q  <= 1'b0;
			end else begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/esd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_queue
	import esd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	esd_out_if.source  tx
);

	out_word_t        ent_q [QDEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QAW:0]     count_q;
	logic             pop;
	logic [QAW-1:0]   wr_nx;

	assign wr_nx = wr_q + QAW'(1);
	assign pop   = tx.valid && tx.ready;
	// Two free slots guarantee any decoded word fits
	assign room  = count_q <= (QAW+1)'(QDEPTH - 2);

	assign tx.valid     = count_q != '0;
	assign tx.out_byte  = ent_q[rd_q].out_byte;
	assign tx.out_valid = ent_q[rd_q].out_valid;
	assign tx.out_end   = ent_q[rd_q].out_end;
	assign tx.out_error = ent_q[rd_q].out_error;

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			ent_q[wr_q] <= push.w0;
		end
		if (push.cnt == 2'd2) begin
			ent_q[wr_nx] <= push.w1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(push.cnt);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + (QAW+1)'(push.cnt) - (QAW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hdl/escape_sequence_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes a C-style escaped string arriving one character per word on rx, the
// final character flagged by in_last, and delivers decoded characters on tx, one
// per word. A character normally yields one word and is taken every cycle while
// the queue has room; one that closes an octal or hex run yields two unless it
// is a backslash, and the final character of a string yields the end word
// (out_end), whose out_error asks the user to discard the string. Each input word
// is held in the input register, where the decode is done, until its results
// enter a four-word result queue that feeds tx directly; the input side takes a
// new word whenever that queue has at least two free slots, so sustained input
// is one word per cycle while tx keeps up; two-word results take an extra tx slot.

module escape_sequence_decoder
	import esd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	esd_in_if.sink     rx,
	esd_out_if.source  tx
);

	push_t push;
	logic  room;

	esd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.room   (room),
		.push   (push)
	);

	esd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tx     (tx)
	);

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import esd_pkg::*;

	localparam int RANDOM_ITEMS   = 1850;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;

	typedef enum logic [2:0] {
		DM_PLAIN  = 3'd0,
		DM_ESC    = 3'd1,
		DM_XSTART = 3'd2,
		DM_HEX    = 3'd3,
		DM_OCT    = 3'd4
	} dec_mode_e;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC
	} rx_pattern_e;

	logic clk;
	logic arst_n;

	esd_in_if  rx_if ();
	esd_out_if tx_if ();

	escape_sequence_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	// Decoder state as predicted from the accepted words
	dec_mode_e  dec_mode;
	logic [7:0] dec_acc;
	logic       dec_err;

	out_word_t expected_words[$];
	int        mismatches;

	// Sender burst control
	int burst_left;
	bit gapless;

	// Receiver hold-off request, serviced by the receiver process
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= CH_D0 && c <= CH_D9)
			return int'(c - CH_D0);
		if (c >= CH_LA && c <= CH_LF)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic int letter_code(input logic [7:0] c);
		case (c)
			CH_LA: return int'(CODE_BEL);
			CH_LB: return int'(CODE_BS);
			CH_LF: return int'(CODE_FF);
			CH_LN: return int'(CODE_LF);
			CH_LR: return int'(CODE_CR);
			CH_LT: return int'(CODE_HT);
			CH_LV: return int'(CODE_VT);
			CH_BSL, CH_QUOTE, CH_DQUOT, CH_QMARK: return int'(c);
			default: return -1;
		endcase
	endfunction

	function automatic void clear_decoder();
		dec_mode = DM_PLAIN;
		dec_acc  = 8'h00;
		dec_err  = 1'b0;
	endfunction

	// Advance the predicted decoder by one character and queue its results
	function automatic void decode_char(input logic [7:0] c, input logic last);
		logic [7:0] em [2];
		int         n;
		int         v;
		logic       to_plain;
		out_word_t  w;
		n        = 0;
		to_plain = 1'b0;
		if (!dec_err) begin
			case (dec_mode)
				DM_ESC: begin
					v = letter_code(c);
					if (v >= 0) begin
						em[n] = v[7:0];
						n++;
						dec_mode = DM_PLAIN;
					end else if (c == CH_LX) begin
						dec_mode = DM_XSTART;
					end else if (c >= CH_D0 && c <= CH_D7) begin
						dec_acc  = c - CH_D0;
						dec_mode = DM_OCT;
					end else begin
						dec_err = 1'b1;
					end
				end
				DM_XSTART: begin
					v = hex_digit(c);
					if (v >= 0) begin
						dec_acc  = v[7:0];
						dec_mode = DM_HEX;
					end else begin
						dec_err = 1'b1;
					end
				end
				DM_HEX: begin
					v = hex_digit(c);
					if (v >= 0) begin
						dec_acc = 8'(int'(dec_acc) * 16 + v);
					end else begin
						em[n] = dec_acc;
						n++;
						dec_acc  = 8'h00;
						to_plain = 1'b1;
					end
				end
				DM_OCT: begin
					if (c >= CH_D0 && c <= CH_D7) begin
						dec_acc = 8'(int'(dec_acc) * 8 + int'(c - CH_D0));
					end else begin
						em[n] = dec_acc;
						n++;
						dec_acc  = 8'h00;
						to_plain = 1'b1;
					end
				end
				// Plain text, and the unused mode codes
				default: to_plain = 1'b1;
			endcase
			if (to_plain) begin
				if (c == CH_BSL) begin
					dec_mode = DM_ESC;
				end else begin
					dec_mode = DM_PLAIN;
					em[n]    = c;
					n++;
				end
			end
		end

		// Close whatever is open on the final character
		if (last && !dec_err) begin
			if (dec_mode == DM_ESC || dec_mode == DM_XSTART) begin
				dec_err = 1'b1;
			end else if (dec_mode == DM_HEX || dec_mode == DM_OCT) begin
				em[n] = dec_acc;
				n++;
			end
		end

		for (int k = 0; k < n; k++) begin
			w.out_byte  = em[k];
			w.out_valid = 1'b1;
			w.out_end   = last && !dec_err && (k == n - 1);
			w.out_error = 1'b0;
			expected_words.push_back(w);
		end
		if (last) begin
			if (dec_err || n == 0) begin
				w.out_byte  = 8'h00;
				w.out_valid = 1'b0;
				w.out_end   = 1'b1;
				w.out_error = dec_err;
				expected_words.push_back(w);
			end
			clear_decoder();
		end
	endfunction

	// Drop valid for a gap, with junk on the data lines
	task automatic idle_sender(input int cycles);
		for (int i = 0; i < cycles; i++) begin
			@(negedge clk);
			rx_if.valid   = 1'b0;
			rx_if.in_byte = 8'($urandom);
			rx_if.in_last = 1'($urandom);
		end
	endtask

	// Offer one word and hold it until the decoder takes it
	task automatic send_char(input logic [7:0] c, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!gapless && $urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 6));
		end
		burst_left--;
		@(negedge clk);
		rx_if.valid   = 1'b1;
		rx_if.in_byte = c;
		rx_if.in_last = last;
		do
			@(posedge clk);
		while (!rx_if.ready);
		decode_char(c, last);
	endtask

	task automatic send_bytes(input logic [7:0] s[$]);
		for (int i = 0; i < s.size(); i++)
			send_char(s[i], i == s.size() - 1);
	endtask

	task automatic send_text(input string t);
		logic [7:0] s[$];
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		send_bytes(s);
	endtask

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 10))
			0: return CH_LA;
			1: return CH_LB;
			2: return CH_LF;
			3: return CH_LN;
			4: return CH_LR;
			5: return CH_LT;
			6: return CH_LV;
			7: return CH_BSL;
			8: return CH_QUOTE;
			9: return CH_DQUOT;
			default: return CH_QMARK;
		endcase
	endfunction

	function automatic logic [7:0] pick_hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return CH_D0 + 8'(v);
		if (v < 16)
			return CH_LA + 8'(v - 10);
		return CH_UA + 8'(v - 16);
	endfunction

	// Build a string from escape tokens; noisy strings may carry broken escapes
	function automatic void build_string(ref logic [7:0] s[$], input bit noisy);
		int         tokens;
		int         r;
		logic [7:0] c;
		s.delete();
		tokens = $urandom_range(1, 10);
		for (int t = 0; t < tokens; t++) begin
			r = noisy ? $urandom_range(0, 99) : $urandom_range(0, 89);
			if (r < 35) begin
				if ($urandom_range(0, 3) == 0)
					c = 8'($urandom);
				else
					c = 8'($urandom_range(8'h20, 8'h7E));
				if (c == CH_BSL)
					c = CH_UA;
				s.push_back(c);
			end else if (r < 60) begin
				s.push_back(CH_BSL);
				s.push_back(pick_letter());
			end else if (r < 75) begin
				s.push_back(CH_BSL);
				repeat ($urandom_range(1, 4))
					s.push_back(CH_D0 + 8'($urandom_range(0, 7)));
			end else if (r < 90) begin
				s.push_back(CH_BSL);
				s.push_back(CH_LX);
				repeat ($urandom_range(1, 4))
					s.push_back(pick_hex_char());
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						s.push_back(CH_BSL);
						s.push_back(8'($urandom));
					end
					1: begin
						s.push_back(CH_BSL);
						s.push_back(CH_LX);
						s.push_back(8'($urandom));
					end
					2: s.push_back(CH_BSL);
					default: s.push_back(8'($urandom));
				endcase
			end
		end
	endfunction

	// Plain bytes at both extremes, letter escapes, octal run closed by a backslash
	task automatic test_plain_and_letters();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("\\a\\101\\b");
	endtask

	// Hex run of mixed case wrapping, closed by a plain byte; octal run open at the end
	task automatic test_digit_runs();
		send_text("\\xA9fz\\777");
	endtask

	// Unknown escape with dropped bytes, trailing backslash after a run,
	// x as the final byte, and x without a hex digit
	task automatic test_bad_escapes();
		send_text("\\qy");
		send_text("\\12\\");
		send_text("\\x");
		send_text("\\xg");
	endtask

	// Keep offering while the receiver holds off, so the result queue fills
	task automatic test_backpressure();
		logic [7:0] s[$];
		gapless  = 1'b1;
		hold_req = 1'b1;
		repeat (4) begin
			build_string(s, 1'b0);
			send_bytes(s);
			repeat (12)
				send_char(CH_UA + 8'($urandom_range(0, 25)), 1'b0);
			send_char(CH_LA, 1'b1);
		end
		gapless = 1'b0;
	endtask

	task automatic test_random_strings();
		logic [7:0] s[$];
		int         sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				gapless = ~gapless;
			build_string(s, $urandom_range(0, 4) == 0);
			send_bytes(s);
			sent += s.size();
		end
		gapless = 1'b0;
	endtask

	// Receiver: long hold-off on request, otherwise a changing stall pattern
	initial begin
		int          hold_left;
		int          pat_left;
		int          pat_phase;
		int          pat_period;
		int          pat_pct;
		rx_pattern_e pat_kind;
		hold_left   = 0;
		pat_left    = 0;
		pat_phase   = 0;
		pat_period  = 2;
		pat_pct     = 50;
		pat_kind    = RX_OPEN;
		tx_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_if.ready = 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_left   = $urandom_range(32, 256);
					pat_kind   = rx_pattern_e'($urandom_range(0, 2));
					pat_period = $urandom_range(2, 7);
					pat_pct    = $urandom_range(20, 90);
				end
				pat_left--;
				pat_phase++;
				case (pat_kind)
					RX_OPEN:   tx_if.ready = 1'b1;
					RX_RANDOM: tx_if.ready = ($urandom_range(0, 99) < pat_pct);
					default:   tx_if.ready = ((pat_phase % pat_period) != 0);
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: out_byte 0x%0h valid %0b end %0b error %0b",
					tx_if.out_byte, tx_if.out_valid, tx_if.out_end, tx_if.out_error);
				mismatches++;
			end else begin
				exp_w = expected_words.pop_front();
				check_field("out_byte", exp_w.out_byte, tx_if.out_byte);
				check_field("out_valid", 8'(exp_w.out_valid), 8'(tx_if.out_valid));
				check_field("out_end", 8'(exp_w.out_end), 8'(tx_if.out_end));
				check_field("out_error", 8'(exp_w.out_error), 8'(tx_if.out_error));
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.in_byte = 8'h00;
		rx_if.in_last = 1'b0;
		mismatches    = 0;
		burst_left    = 0;
		gapless       = 1'b0;
		hold_req      = 1'b0;
		clear_decoder();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_and_letters();
		test_digit_runs();
		test_bad_escapes();
		test_backpressure();
		test_random_strings();

		// Drain and let the pipeline settle
		@(negedge clk);
		rx_if.valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
hdl/esd_pkg.sv
hdl/esd_if.sv
hdl/esd_decode.sv
hdl/esd_queue.sv
hdl/escape_sequence_decoder.sv
tb/tb.sv
